### rtl/obb2d_overlap_test_assert.svh
// ----------------------------------------------------------------------------
// obb2d_overlap_test_assert.svh
// assertion macros shared by the oriented box overlap pipeline
// ----------------------------------------------------------------------------
`ifndef OBB2D_OVERLAP_TEST_ASSERT_SVH
`define OBB2D_OVERLAP_TEST_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define OBB2D_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OBB2D_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define OBB2D_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define OBB2D_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

### rtl/obb2d_pkg.sv
// ----------------------------------------------------------------------------
// obb2d_pkg
// shared constants and helpers for the oriented box overlap pipeline
// ----------------------------------------------------------------------------
package obb2d_pkg;

  localparam int unsigned NUM_AXES = 4;

  // slots of the half extent vector
  localparam int unsigned IDX_AW = 0;
  localparam int unsigned IDX_AH = 1;
  localparam int unsigned IDX_BW = 2;
  localparam int unsigned IDX_BH = 3;

  function automatic int unsigned wmax(input int unsigned x, input int unsigned y);
    return (x > y) ? x : y;
  endfunction

endpackage

### rtl/obb2d_proj.sv
// ----------------------------------------------------------------------------
// obb2d_proj
// two pipeline stages: center offset and axis products, then sums and magnitudes
// ----------------------------------------------------------------------------
module obb2d_proj #(
  parameter int unsigned CW = 16,
  parameter int unsigned TW = 16,
  parameter int unsigned HW = 15
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           vld_i,
  output logic                                           rdy_o,
  input  logic signed [CW-1:0]                           acx_i,
  input  logic signed [CW-1:0]                           acy_i,
  input  logic signed [CW-1:0]                           bcx_i,
  input  logic signed [CW-1:0]                           bcy_i,
  input  logic signed [TW-1:0]                           aux_i,
  input  logic signed [TW-1:0]                           auy_i,
  input  logic signed [TW-1:0]                           bux_i,
  input  logic signed [TW-1:0]                           buy_i,
  input  logic [obb2d_pkg::NUM_AXES-1:0][HW-1:0]         half_i,
  output logic                                           vld_o,
  input  logic                                           rdy_i,
  output logic [obb2d_pkg::NUM_AXES-1:0][CW+TW:0]        dist_o,
  output logic [2*TW-1:0]                                na_o,
  output logic [2*TW-1:0]                                nb_o,
  output logic [2*TW-1:0]                                cabs_o,
  output logic [2*TW-1:0]                                sabs_o,
  output logic [obb2d_pkg::NUM_AXES-1:0][HW-1:0]         half_o
);

  localparam int unsigned PW = CW + TW + 1;
  localparam int unsigned NW = 2 * TW;

  function automatic logic [PW-1:0] mag_d(input logic signed [PW:0] v);
    logic signed [PW:0] m;
    m = v[PW] ? -v : v;
    return m[PW-1:0];
  endfunction

  function automatic logic [NW-1:0] mag_n(input logic signed [NW:0] v);
    logic signed [NW:0] m;
    m = v[NW] ? -v : v;
    return m[NW-1:0];
  endfunction

  logic v1_r, v2_r;
  logic rdy1, rdy2;

  logic signed [CW:0] dx, dy;

  // stage 1 products
  logic signed [PW-1:0] dax_nxt, day_nxt, dau_nxt, dya_nxt;
  logic signed [PW-1:0] dbx_nxt, dby_nxt, dbu_nxt, dyb_nxt;
  logic signed [NW-1:0] axx_nxt, ayy_nxt, bxx_nxt, byy_nxt;
  logic signed [NW-1:0] xx_nxt, yy_nxt, xy_nxt, yx_nxt;

  logic signed [PW-1:0] dax_r, day_r, dau_r, dya_r;
  logic signed [PW-1:0] dbx_r, dby_r, dbu_r, dyb_r;
  logic signed [NW-1:0] axx_r, ayy_r, bxx_r, byy_r;
  logic signed [NW-1:0] xx_r, yy_r, xy_r, yx_r;
  logic [obb2d_pkg::NUM_AXES-1:0][HW-1:0] half1_r;

  // stage 2 sums
  logic signed [PW:0] d0, d1, d2, d3;
  logic signed [NW:0] na_s, nb_s, c_s, s_s;
  logic [obb2d_pkg::NUM_AXES-1:0][PW-1:0] dist_nxt;
  logic [NW-1:0] na_nxt, nb_nxt, cabs_nxt, sabs_nxt;

  logic [obb2d_pkg::NUM_AXES-1:0][PW-1:0] dist_r;
  logic [NW-1:0] na_r, nb_r, cabs_r, sabs_r;
  logic [obb2d_pkg::NUM_AXES-1:0][HW-1:0] half2_r;

  assign rdy2  = !v2_r || rdy_i;
  assign rdy1  = !v1_r || rdy2;
  assign rdy_o = rdy1;

  always_comb begin
    dx = {bcx_i[CW-1], bcx_i} - {acx_i[CW-1], acx_i};
    dy = {bcy_i[CW-1], bcy_i} - {acy_i[CW-1], acy_i};
    dax_nxt = PW'(dx) * PW'(aux_i);
    day_nxt = PW'(dy) * PW'(auy_i);
    dau_nxt = PW'(dx) * PW'(auy_i);
    dya_nxt = PW'(dy) * PW'(aux_i);
    dbx_nxt = PW'(dx) * PW'(bux_i);
    dby_nxt = PW'(dy) * PW'(buy_i);
    dbu_nxt = PW'(dx) * PW'(buy_i);
    dyb_nxt = PW'(dy) * PW'(bux_i);
    axx_nxt = NW'(aux_i) * NW'(aux_i);
    ayy_nxt = NW'(auy_i) * NW'(auy_i);
    bxx_nxt = NW'(bux_i) * NW'(bux_i);
    byy_nxt = NW'(buy_i) * NW'(buy_i);
    xx_nxt  = NW'(aux_i) * NW'(bux_i);
    yy_nxt  = NW'(auy_i) * NW'(buy_i);
    xy_nxt  = NW'(aux_i) * NW'(buy_i);
    yx_nxt  = NW'(auy_i) * NW'(bux_i);
  end

  always_comb begin
    // axis order: a.x, a.y, b.x, b.y
    d0 = (PW+1)'(dax_r) + (PW+1)'(day_r);
    d1 = (PW+1)'(dya_r) - (PW+1)'(dau_r);
    d2 = (PW+1)'(dbx_r) + (PW+1)'(dby_r);
    d3 = (PW+1)'(dyb_r) - (PW+1)'(dbu_r);
    dist_nxt[0] = mag_d(d0);
    dist_nxt[1] = mag_d(d1);
    dist_nxt[2] = mag_d(d2);
    dist_nxt[3] = mag_d(d3);
    na_s = (NW+1)'(axx_r) + (NW+1)'(ayy_r);
    nb_s = (NW+1)'(bxx_r) + (NW+1)'(byy_r);
    c_s  = (NW+1)'(xx_r) + (NW+1)'(yy_r);
    s_s  = (NW+1)'(xy_r) - (NW+1)'(yx_r);
    na_nxt   = na_s[NW-1:0];
    nb_nxt   = nb_s[NW-1:0];
    cabs_nxt = mag_n(c_s);
    sabs_nxt = mag_n(s_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= vld_i;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dax_r   <= dax_nxt;
      day_r   <= day_nxt;
      dau_r   <= dau_nxt;
      dya_r   <= dya_nxt;
      dbx_r   <= dbx_nxt;
      dby_r   <= dby_nxt;
      dbu_r   <= dbu_nxt;
      dyb_r   <= dyb_nxt;
      axx_r   <= axx_nxt;
      ayy_r   <= ayy_nxt;
      bxx_r   <= bxx_nxt;
      byy_r   <= byy_nxt;
      xx_r    <= xx_nxt;
      yy_r    <= yy_nxt;
      xy_r    <= xy_nxt;
      yx_r    <= yx_nxt;
      half1_r <= half_i;
    end
    if (rdy2) begin
      dist_r  <= dist_nxt;
      na_r    <= na_nxt;
      nb_r    <= nb_nxt;
      cabs_r  <= cabs_nxt;
      sabs_r  <= sabs_nxt;
      half2_r <= half1_r;
    end
  end

  assign vld_o  = v2_r;
  assign dist_o = dist_r;
  assign na_o   = na_r;
  assign nb_o   = nb_r;
  assign cabs_o = cabs_r;
  assign sabs_o = sabs_r;
  assign half_o = half2_r;

`include "obb2d_overlap_test_assert.svh"

  // a blocked product stage keeps its transaction
`OBB2D_ASSERT_NXT(a_prod_hold, clk, rst_n, v1_r && !rdy2, v1_r && $stable(dax_r) && $stable(xy_r), "product stage lost data while blocked")

endmodule

### rtl/obb2d_ext.sv
// ----------------------------------------------------------------------------
// obb2d_ext
// two pipeline stages: extent products, then per-axis reach sums
// ----------------------------------------------------------------------------
module obb2d_ext #(
  parameter int unsigned NW = 32,
  parameter int unsigned HW = 15,
  parameter int unsigned PW = 33
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           vld_i,
  output logic                                           rdy_o,
  input  logic [obb2d_pkg::NUM_AXES-1:0][PW-1:0]         dist_i,
  input  logic [NW-1:0]                                  na_i,
  input  logic [NW-1:0]                                  nb_i,
  input  logic [NW-1:0]                                  cabs_i,
  input  logic [NW-1:0]                                  sabs_i,
  input  logic [obb2d_pkg::NUM_AXES-1:0][HW-1:0]         half_i,
  output logic                                           vld_o,
  input  logic                                           rdy_i,
  output logic [obb2d_pkg::NUM_AXES-1:0][PW-1:0]         dist_o,
  output logic [obb2d_pkg::NUM_AXES-1:0][NW+HW+1:0]      reach_o
);

  localparam int unsigned EW = NW + HW;
  localparam int unsigned RW = EW + 2;

  logic v3_r, v4_r;
  logic rdy3, rdy4;

  logic [1:0][EW-1:0] ma_nxt, mb_nxt, ma_r, mb_r;
  logic [obb2d_pkg::NUM_AXES-1:0][EW-1:0] mc_nxt, ms_nxt, mc_r, ms_r;
  logic [obb2d_pkg::NUM_AXES-1:0][PW-1:0] dist3_r, dist4_r;
  logic [obb2d_pkg::NUM_AXES-1:0][RW-1:0] reach_nxt, reach_r;

  assign rdy4  = !v4_r || rdy_i;
  assign rdy3  = !v3_r || rdy4;
  assign rdy_o = rdy3;

  always_comb begin
    ma_nxt[0] = EW'(na_i) * EW'(half_i[obb2d_pkg::IDX_AW]);
    ma_nxt[1] = EW'(na_i) * EW'(half_i[obb2d_pkg::IDX_AH]);
    mb_nxt[0] = EW'(nb_i) * EW'(half_i[obb2d_pkg::IDX_BW]);
    mb_nxt[1] = EW'(nb_i) * EW'(half_i[obb2d_pkg::IDX_BH]);
    for (int k = 0; k < obb2d_pkg::NUM_AXES; k++) begin
      mc_nxt[k] = EW'(cabs_i) * EW'(half_i[k]);
      ms_nxt[k] = EW'(sabs_i) * EW'(half_i[k]);
    end
  end

  always_comb begin
    reach_nxt[0] = RW'(ma_r[0]) + RW'(mc_r[obb2d_pkg::IDX_BW]) + RW'(ms_r[obb2d_pkg::IDX_BH]);
    reach_nxt[1] = RW'(ma_r[1]) + RW'(ms_r[obb2d_pkg::IDX_BW]) + RW'(mc_r[obb2d_pkg::IDX_BH]);
    reach_nxt[2] = RW'(mb_r[0]) + RW'(mc_r[obb2d_pkg::IDX_AW]) + RW'(ms_r[obb2d_pkg::IDX_AH]);
    reach_nxt[3] = RW'(mb_r[1]) + RW'(ms_r[obb2d_pkg::IDX_AW]) + RW'(mc_r[obb2d_pkg::IDX_AH]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy3) begin
        v3_r <= vld_i;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      ma_r    <= ma_nxt;
      mb_r    <= mb_nxt;
      mc_r    <= mc_nxt;
      ms_r    <= ms_nxt;
      dist3_r <= dist_i;
    end
    if (rdy4) begin
      reach_r <= reach_nxt;
      dist4_r <= dist3_r;
    end
  end

  assign vld_o   = v4_r;
  assign dist_o  = dist4_r;
  assign reach_o = reach_r;

`include "obb2d_overlap_test_assert.svh"

  // a blocked reach stage keeps its transaction
`OBB2D_ASSERT_NXT(a_reach_hold, clk, rst_n, v4_r && !rdy_i, v4_r && $stable(reach_r) && $stable(dist4_r), "reach stage lost data while blocked")

endmodule

### rtl/obb2d_overlap_test.sv
// Oriented 2D box overlap test by separating axes. One box pair is taken per
// clock cycle while in_stall is low, and every pair gives one overlap bit; the
// result reaches out_valid through six register stages (input, axis
// products, sums and magnitudes, extent products, reach sums, compare and
// output). The stages close up bubbles, so a new pair is still accepted while
// a finished result waits on out_stall, as long as some stage ahead of it is
// empty.
// ----------------------------------------------------------------------------
// obb2d_overlap_test
// separating axis overlap test for two oriented boxes, fully pipelined
// ----------------------------------------------------------------------------
module obb2d_overlap_test #(
  parameter int unsigned COORD_BITS     = 16,
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COORD_BITS-1:0]     in_a_center_x,
  input  logic signed [COORD_BITS-1:0]     in_a_center_y,
  input  logic [COORD_BITS-2:0]            in_a_half_w,
  input  logic [COORD_BITS-2:0]            in_a_half_h,
  input  logic signed [TRIG_FRAC_BITS+1:0] in_a_cos,
  input  logic signed [TRIG_FRAC_BITS+1:0] in_a_sin,
  input  logic signed [COORD_BITS-1:0]     in_b_center_x,
  input  logic signed [COORD_BITS-1:0]     in_b_center_y,
  input  logic [COORD_BITS-2:0]            in_b_half_w,
  input  logic [COORD_BITS-2:0]            in_b_half_h,
  input  logic signed [TRIG_FRAC_BITS+1:0] in_b_cos,
  input  logic signed [TRIG_FRAC_BITS+1:0] in_b_sin,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_overlap
);

  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned TW   = TRIG_FRAC_BITS + 2;
  localparam int unsigned HW   = COORD_BITS - 1;
  localparam int unsigned PW   = CW + TW + 1;
  localparam int unsigned NW   = 2 * TW;
  localparam int unsigned RW   = NW + HW + 2;
  localparam int unsigned CMPW = obb2d_pkg::wmax(RW, PW + TRIG_FRAC_BITS);

  logic v0_r, v5_r;
  logic rdy0, rdy1, rdy5;

  logic signed [CW-1:0] acx_r, acy_r, bcx_r, bcy_r;
  logic signed [TW-1:0] aux_r, auy_r, bux_r, buy_r;
  logic [obb2d_pkg::NUM_AXES-1:0][HW-1:0] half0_r;

  logic                                   pv;
  logic                                   ext_rdy;
  logic [obb2d_pkg::NUM_AXES-1:0][PW-1:0] pdist;
  logic [NW-1:0]                          pna, pnb, pcabs, psabs;
  logic [obb2d_pkg::NUM_AXES-1:0][HW-1:0] phalf;

  logic                                   ev;
  logic [obb2d_pkg::NUM_AXES-1:0][PW-1:0] edist;
  logic [obb2d_pkg::NUM_AXES-1:0][RW-1:0] ereach;

  logic [obb2d_pkg::NUM_AXES-1:0] sep;
  logic                           overlap_nxt;
  logic                           overlap_r;

  assign rdy5     = !v5_r || !out_stall;
  assign rdy0     = !v0_r || rdy1;
  assign in_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_r <= in_valid;
      end
      if (rdy5) begin
        v5_r <= ev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      acx_r   <= in_a_center_x;
      acy_r   <= in_a_center_y;
      bcx_r   <= in_b_center_x;
      bcy_r   <= in_b_center_y;
      aux_r   <= in_a_cos;
      auy_r   <= in_a_sin;
      bux_r   <= in_b_cos;
      buy_r   <= in_b_sin;
      half0_r[obb2d_pkg::IDX_AW] <= in_a_half_w;
      half0_r[obb2d_pkg::IDX_AH] <= in_a_half_h;
      half0_r[obb2d_pkg::IDX_BW] <= in_b_half_w;
      half0_r[obb2d_pkg::IDX_BH] <= in_b_half_h;
    end
    if (rdy5) begin
      overlap_r <= overlap_nxt;
    end
  end

  obb2d_proj #(
    .CW (CW),
    .TW (TW),
    .HW (HW)
  ) u_proj (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (v0_r),
    .rdy_o  (rdy1),
    .acx_i  (acx_r),
    .acy_i  (acy_r),
    .bcx_i  (bcx_r),
    .bcy_i  (bcy_r),
    .aux_i  (aux_r),
    .auy_i  (auy_r),
    .bux_i  (bux_r),
    .buy_i  (buy_r),
    .half_i (half0_r),
    .vld_o  (pv),
    .rdy_i  (ext_rdy),
    .dist_o (pdist),
    .na_o   (pna),
    .nb_o   (pnb),
    .cabs_o (pcabs),
    .sabs_o (psabs),
    .half_o (phalf)
  );

  obb2d_ext #(
    .NW (NW),
    .HW (HW),
    .PW (PW)
  ) u_ext (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (pv),
    .rdy_o   (ext_rdy),
    .dist_i  (pdist),
    .na_i    (pna),
    .nb_i    (pnb),
    .cabs_i  (pcabs),
    .sabs_i  (psabs),
    .half_i  (phalf),
    .vld_o   (ev),
    .rdy_i   (rdy5),
    .dist_o  (edist),
    .reach_o (ereach)
  );

  // touching boxes still overlap: separation needs a strict excess
  always_comb begin
    for (int k = 0; k < obb2d_pkg::NUM_AXES; k++) begin
      sep[k] = CMPW'({edist[k], {TRIG_FRAC_BITS{1'b0}}}) > CMPW'(ereach[k]);
    end
    overlap_nxt = !(|sep);
  end

  assign out_valid   = v5_r;
  assign out_overlap = overlap_r;

`include "obb2d_overlap_test_assert.svh"

  // with the output stage empty the whole pipe can move
`OBB2D_ASSERT_IMP(a_empty_no_stall, clk, rst_n, !v5_r, !in_stall, "input stalled with empty output stage")
  // a held result never drops while blocked
`OBB2D_ASSERT_NXT(a_out_keep, clk, rst_n, v5_r && out_stall, v5_r && $stable(overlap_r), "output stage lost a blocked result")

endmodule
